// ----- design/versioned_double_hash_table_assert.svh -----
// Assertion helpers for the versioned double-hash table.
// The guard keeps a second include from redefining the macros.
`ifndef VERSIONED_DOUBLE_HASH_TABLE_ASSERT_SVH
`define VERSIONED_DOUBLE_HASH_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VDHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VDHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/vdht_pkg.sv -----
// ----------------------------------------------------------------------------
// vdht_pkg
// Types and codes used by the versioned double-hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package vdht_pkg;

  localparam int CFG_W   = 10;
  localparam int MAX_OUT = 8;
  localparam int OCNT_W  = 4;

  typedef enum logic [2:0] {
    MD_INSERT   = 3'd0,
    MD_FIND_KEY = 3'd1,
    MD_FIND_REL = 3'd2,
    MD_DEL_KEY  = 3'd3,
    MD_DEL_REL  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_RECFULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SL_EMPTY = 2'd0,
    SL_BUSY  = 2'd1,
    SL_TOMB  = 2'd2
  } slot_st_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_INIT,
    S_PRB_RD,
    S_PRB_CHK,
    S_WALK_DONE,
    S_FK_START,
    S_REC_RD,
    S_REC_CHK,
    S_REC_DONE,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] key;
    logic [15:0]        release_req;
    logic [31:0]        value;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [9:0]  slot;
    logic [15:0] release_out;
    logic [31:0] value_out;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] rel;
    logic [31:0] val;
  } rec_t;

endpackage

`default_nettype wire

// ----- design/vdht_ram.sv -----
// ----------------------------------------------------------------------------
// vdht_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module vdht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ----- design/versioned_double_hash_table.sv -----
// After reset the block sweeps the slot memory once, one slot a cycle, and
// takes no request until that is done. Each request then derives the first
// probe and the step (one remainder bit a cycle, both remainders together),
// then reads and checks each probe along the chain, and each release record
// when the key's records are scanned; find key scans the records once per
// reported release, and once more when fewer than MAX_OUT are found, up to
// MAX_OUT scans in all. Every result waits in the output register until taken.
// ----------------------------------------------------------------------------
// versioned_double_hash_table
// Open-addressed table of signed keys with double hashing and per-key
// release records, kept in a slot memory and a record memory.
// ----------------------------------------------------------------------------
`default_nettype none

`include "versioned_double_hash_table_assert.svh"

module versioned_double_hash_table #(
  parameter int TABLE_SLOTS     = 1024,
  parameter int RECORDS_PER_KEY = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [9:0]            cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire vdht_pkg::in_item_t    in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output vdht_pkg::out_item_t        out_data_o
);

  localparam int CW      = vdht_pkg::CFG_W;
  localparam int SLOT_W  = $clog2(TABLE_SLOTS);
  localparam int REC_W   = $clog2(TABLE_SLOTS * RECORDS_PER_KEY);
  localparam int RW      = (RECORDS_PER_KEY > 1) ? $clog2(RECORDS_PER_KEY) : 1;
  localparam int CNT_W   = $clog2(RECORDS_PER_KEY + 1);
  localparam int MaxSzI  = (TABLE_SLOTS - 1 > 1023) ? 1023 : TABLE_SLOTS - 1;
  localparam int REC_BITS = $bits(vdht_pkg::rec_t);

  typedef struct packed {
    logic [RECORDS_PER_KEY-1:0] vld;
    logic [31:0]                key;
    logic [1:0]                 st;
  } row_t;

  localparam int ROW_BITS = $bits(row_t);

  vdht_pkg::state_e    state_q, state_d;
  logic [CW-1:0]       size_q, size_d;
  vdht_pkg::in_item_t  item_q, item_d;
  logic [CW-1:0]       sz_q, sz_d;
  logic [31:0]         mag_q, mag_d;
  logic [CW-1:0]       rem1_q, rem1_d, rem2_q, rem2_d;
  logic [4:0]          dcnt_q, dcnt_d;
  logic [CW-1:0]       j_q, j_d, h_q, h_d, n_q, n_d, free_q, free_d;
  logic                have_free_q, have_free_d, found_q, found_d;
  row_t                row_q, row_d;
  logic [CNT_W-1:0]    rcnt_q, rcnt_d;
  logic [15:0]         hi_q, hi_d;
  logic                match_q, match_d;
  logic [RW-1:0]       midx_q, midx_d;
  logic [31:0]         mval_q, mval_d;
  logic                best_q, best_d;
  logic [15:0]         bestrel_q, bestrel_d;
  logic [31:0]         bestval_q, bestval_d;
  logic [16:0]         bound_q, bound_d;
  logic [vdht_pkg::OCNT_W-1:0] fcnt_q, fcnt_d;
  logic                pend_q, pend_d;
  logic [15:0]         pend_rel_q, pend_rel_d;
  logic [31:0]         pend_val_q, pend_val_d;
  logic                more_q, more_d;
  logic                out_valid_q, out_valid_d;
  vdht_pkg::out_item_t out_q, out_d;
  logic [SLOT_W-1:0]   clr_q, clr_d;

  logic                slot_we;
  logic [SLOT_W-1:0]   slot_waddr, slot_raddr;
  row_t                slot_wdata, slot_rdata;
  logic                rec_we;
  logic [REC_W-1:0]    rec_waddr, rec_raddr;
  vdht_pkg::rec_t      rec_wdata, rec_rdata;

  logic [CW-1:0]       eff_sz;
  logic [CW-1:0]       sat_sz;
  logic [31:0]         kraw;
  logic [CW:0]         t1, t2, d1, d2, jn;
  logic [REC_W-1:0]    rec_base;
  logic [RW-1:0]       spare;
  logic                spare_ok;
  logic [RECORDS_PER_KEY-1:0] vld_left;

  vdht_ram #(.WIDTH(ROW_BITS), .DEPTH(TABLE_SLOTS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  vdht_ram #(.WIDTH(REC_BITS), .DEPTH(TABLE_SLOTS * RECORDS_PER_KEY)) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (rec_waddr),
    .wdata_i (rec_wdata),
    .raddr_i (rec_raddr),
    .rdata_o (rec_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != vdht_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Out-of-range sizes saturate to TABLE_SLOTS-1 (at most 1023) and are never below three.
  assign sat_sz = (size_q > CW'(MaxSzI)) ? CW'(MaxSzI) : size_q;
  assign eff_sz = (sat_sz < CW'(3)) ? CW'(3) : sat_sz;
  assign kraw   = in_data_i.key;

  assign d1 = {1'b0, sz_q};
  assign d2 = {2'b00, sz_q[CW-1:1]};
  assign t1 = {rem1_q, mag_q[31]};
  assign t2 = {rem2_q, mag_q[31]};
  assign jn = {1'b0, j_q} + {1'b0, h_q};

  assign rec_base = REC_W'(SLOT_W'(j_q)) * REC_W'(RECORDS_PER_KEY);

  always_comb begin
    spare    = '0;
    spare_ok = 1'b0;
    for (int r = RECORDS_PER_KEY - 1; r >= 0; r--) begin
      if (!row_q.vld[r]) begin
        spare    = RW'(r);
        spare_ok = 1'b1;
      end
    end
  end

  assign vld_left = row_q.vld & ~(RECORDS_PER_KEY'(1) << midx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vdht_pkg::S_CLEAR;
      size_q      <= CW'(1023);
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      more_q      <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      size_q      <= size_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      more_q      <= more_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    sz_q        <= sz_d;
    mag_q       <= mag_d;
    rem1_q      <= rem1_d;
    rem2_q      <= rem2_d;
    dcnt_q      <= dcnt_d;
    j_q         <= j_d;
    h_q         <= h_d;
    n_q         <= n_d;
    free_q      <= free_d;
    have_free_q <= have_free_d;
    found_q     <= found_d;
    row_q       <= row_d;
    rcnt_q      <= rcnt_d;
    hi_q        <= hi_d;
    match_q     <= match_d;
    midx_q      <= midx_d;
    mval_q      <= mval_d;
    best_q      <= best_d;
    bestrel_q   <= bestrel_d;
    bestval_q   <= bestval_d;
    bound_q     <= bound_d;
    fcnt_q      <= fcnt_d;
    pend_rel_q  <= pend_rel_d;
    pend_val_q  <= pend_val_d;
    out_q       <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    size_d      = size_q;
    item_d      = item_q;
    sz_d        = sz_q;
    mag_d       = mag_q;
    rem1_d      = rem1_q;
    rem2_d      = rem2_q;
    dcnt_d      = dcnt_q;
    j_d         = j_q;
    h_d         = h_q;
    n_d         = n_q;
    free_d      = free_q;
    have_free_d = have_free_q;
    found_d     = found_q;
    row_d       = row_q;
    rcnt_d      = rcnt_q;
    hi_d        = hi_q;
    match_d     = match_q;
    midx_d      = midx_q;
    mval_d      = mval_q;
    best_d      = best_q;
    bestrel_d   = bestrel_q;
    bestval_d   = bestval_q;
    bound_d     = bound_q;
    fcnt_d      = fcnt_q;
    pend_d      = pend_q;
    pend_rel_d  = pend_rel_q;
    pend_val_d  = pend_val_q;
    more_d      = more_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    clr_d       = clr_q;

    slot_we    = 1'b0;
    slot_waddr = SLOT_W'(j_q);
    slot_wdata = row_q;
    slot_raddr = SLOT_W'(j_q);
    rec_we     = 1'b0;
    rec_waddr  = rec_base;
    rec_wdata  = '{rel: 16'd0, val: item_q.value};
    rec_raddr  = rec_base + REC_W'(rcnt_q);

    if (cfg_valid_i) begin
      size_d = cfg_data_i;
    end

    unique case (state_q)
      vdht_pkg::S_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_q;
        slot_wdata = '{vld: '0, key: 32'd0, st: vdht_pkg::SL_EMPTY};
        clr_d      = clr_q + SLOT_W'(1);
        if (clr_q == SLOT_W'(TABLE_SLOTS - 1)) begin
          state_d = vdht_pkg::S_IDLE;
        end
      end

      vdht_pkg::S_IDLE: begin
        if (in_valid_i) begin
          item_d = in_data_i;
          sz_d   = eff_sz;
          mag_d  = kraw[31] ? (32'd0 - kraw) : kraw;
          rem1_d = '0;
          rem2_d = '0;
          dcnt_d = '0;
          if (in_data_i.mode > vdht_pkg::MD_DEL_REL) begin
            out_d       = '{status: vdht_pkg::ST_NOTFOUND, slot: '0, release_out: '0,
                            value_out: '0, last: 1'b1};
            out_valid_d = 1'b1;
            more_d      = 1'b0;
            state_d     = vdht_pkg::S_EMIT;
          end else begin
            state_d = vdht_pkg::S_DIV;
          end
        end
      end

      // Both remainders in one restoring pass, one key bit per cycle.
      vdht_pkg::S_DIV: begin
        rem1_d = (t1 >= d1) ? CW'(t1 - d1) : CW'(t1);
        rem2_d = (t2 >= d2) ? CW'(t2 - d2) : CW'(t2);
        mag_d  = {mag_q[30:0], 1'b0};
        dcnt_d = dcnt_q + 5'd1;
        if (dcnt_q == 5'd31) begin
          state_d = vdht_pkg::S_INIT;
        end
      end

      vdht_pkg::S_INIT: begin
        j_d         = rem1_q;
        h_d         = rem2_q + CW'(1);
        n_d         = '0;
        have_free_d = 1'b0;
        found_d     = 1'b0;
        state_d     = vdht_pkg::S_PRB_RD;
      end

      vdht_pkg::S_PRB_RD: begin
        state_d = vdht_pkg::S_PRB_CHK;
      end

      vdht_pkg::S_PRB_CHK: begin
        if (slot_rdata.st == vdht_pkg::SL_EMPTY) begin
          if (!have_free_q) begin
            have_free_d = 1'b1;
            free_d      = j_q;
          end
          state_d = vdht_pkg::S_WALK_DONE;
        end else if (slot_rdata.st == vdht_pkg::SL_BUSY &&
                     slot_rdata.key == item_q.key) begin
          found_d = 1'b1;
          row_d   = slot_rdata;
          state_d = vdht_pkg::S_WALK_DONE;
        end else begin
          if (slot_rdata.st != vdht_pkg::SL_BUSY && !have_free_q) begin
            have_free_d = 1'b1;
            free_d      = j_q;
          end
          j_d = (jn >= d1) ? CW'(jn - d1) : CW'(jn);
          n_d = n_q + CW'(1);
          if (n_q + CW'(1) == sz_q) begin
            state_d = vdht_pkg::S_WALK_DONE;
          end else begin
            state_d = vdht_pkg::S_PRB_RD;
          end
        end
      end

      vdht_pkg::S_WALK_DONE: begin
        out_d  = '{status: vdht_pkg::ST_NOTFOUND, slot: '0, release_out: '0,
                   value_out: '0, last: 1'b1};
        more_d = 1'b0;
        rcnt_d = '0;
        hi_d   = '0;
        match_d = 1'b0;
        if (!found_q) begin
          if (item_q.mode == vdht_pkg::MD_INSERT) begin
            if (have_free_q) begin
              slot_we    = 1'b1;
              slot_waddr = SLOT_W'(free_q);
              slot_wdata = '{vld: RECORDS_PER_KEY'(1), key: item_q.key,
                             st: vdht_pkg::SL_BUSY};
              rec_we     = 1'b1;
              rec_waddr  = REC_W'(SLOT_W'(free_q)) * REC_W'(RECORDS_PER_KEY);
              rec_wdata  = '{rel: 16'd1, val: item_q.value};
              out_d      = '{status: vdht_pkg::ST_OK, slot: free_q, release_out: 16'd1,
                             value_out: item_q.value, last: 1'b1};
            end else begin
              out_d.status = vdht_pkg::ST_FULL;
            end
          end
          out_valid_d = 1'b1;
          state_d     = vdht_pkg::S_EMIT;
        end else if (item_q.mode == vdht_pkg::MD_DEL_KEY) begin
          slot_we     = 1'b1;
          slot_wdata  = '{vld: '0, key: row_q.key, st: vdht_pkg::SL_TOMB};
          out_d       = '{status: vdht_pkg::ST_OK, slot: j_q, release_out: '0,
                          value_out: '0, last: 1'b1};
          out_valid_d = 1'b1;
          state_d     = vdht_pkg::S_EMIT;
        end else if (item_q.mode == vdht_pkg::MD_FIND_KEY) begin
          fcnt_d  = '0;
          pend_d  = 1'b0;
          bound_d = 17'h10000;
          state_d = vdht_pkg::S_FK_START;
        end else begin
          state_d = vdht_pkg::S_REC_RD;
        end
      end

      vdht_pkg::S_FK_START: begin
        if (fcnt_q == vdht_pkg::OCNT_W'(vdht_pkg::MAX_OUT)) begin
          out_d       = '{status: vdht_pkg::ST_OK, slot: j_q, release_out: pend_rel_q,
                          value_out: pend_val_q, last: 1'b1};
          out_valid_d = 1'b1;
          more_d      = 1'b0;
          state_d     = vdht_pkg::S_EMIT;
        end else begin
          rcnt_d    = '0;
          best_d    = 1'b0;
          bestrel_d = '0;
          state_d   = vdht_pkg::S_REC_RD;
        end
      end

      vdht_pkg::S_REC_RD: begin
        state_d = vdht_pkg::S_REC_CHK;
      end

      vdht_pkg::S_REC_CHK: begin
        if (row_q.vld[rcnt_q[RW-1:0]]) begin
          if (rec_rdata.rel > hi_q) begin
            hi_d = rec_rdata.rel;
          end
          if (!match_q && rec_rdata.rel == item_q.release_req) begin
            match_d = 1'b1;
            midx_d  = rcnt_q[RW-1:0];
            mval_d  = rec_rdata.val;
          end
          if ({1'b0, rec_rdata.rel} < bound_q && rec_rdata.rel > bestrel_q) begin
            best_d    = 1'b1;
            bestrel_d = rec_rdata.rel;
            bestval_d = rec_rdata.val;
          end
        end
        rcnt_d = rcnt_q + CNT_W'(1);
        if (rcnt_q == CNT_W'(RECORDS_PER_KEY - 1)) begin
          state_d = vdht_pkg::S_REC_DONE;
        end else begin
          state_d = vdht_pkg::S_REC_RD;
        end
      end

      vdht_pkg::S_REC_DONE: begin
        out_d       = '{status: vdht_pkg::ST_NOTFOUND, slot: '0, release_out: '0,
                        value_out: '0, last: 1'b1};
        out_valid_d = 1'b1;
        more_d      = 1'b0;
        state_d     = vdht_pkg::S_EMIT;
        case (item_q.mode)
          vdht_pkg::MD_INSERT: begin
            if (!spare_ok || hi_q == 16'hFFFF) begin
              out_d.status = vdht_pkg::ST_RECFULL;
              out_d.slot   = j_q;
            end else begin
              rec_we     = 1'b1;
              rec_waddr  = rec_base + REC_W'(spare);
              rec_wdata  = '{rel: hi_q + 16'd1, val: item_q.value};
              slot_we    = 1'b1;
              slot_wdata = '{vld: row_q.vld | (RECORDS_PER_KEY'(1) << spare),
                             key: row_q.key, st: vdht_pkg::SL_BUSY};
              out_d      = '{status: vdht_pkg::ST_OK, slot: j_q, release_out: hi_q + 16'd1,
                             value_out: item_q.value, last: 1'b1};
            end
          end
          vdht_pkg::MD_FIND_REL: begin
            if (match_q) begin
              out_d = '{status: vdht_pkg::ST_OK, slot: j_q, release_out: item_q.release_req,
                        value_out: mval_q, last: 1'b1};
            end
          end
          vdht_pkg::MD_DEL_REL: begin
            if (match_q) begin
              slot_we    = 1'b1;
              slot_wdata = '{vld: vld_left, key: row_q.key,
                             st: (|vld_left) ? vdht_pkg::SL_BUSY : vdht_pkg::SL_TOMB};
              out_d = '{status: vdht_pkg::ST_OK, slot: j_q, release_out: item_q.release_req,
                        value_out: mval_q, last: 1'b1};
            end
          end
          default: begin
            // Find key: a result is held back one scan so its last flag is known.
            if (best_q) begin
              fcnt_d     = fcnt_q + vdht_pkg::OCNT_W'(1);
              bound_d    = {1'b0, bestrel_q};
              pend_d     = 1'b1;
              pend_rel_d = bestrel_q;
              pend_val_d = bestval_q;
              if (pend_q) begin
                out_d  = '{status: vdht_pkg::ST_OK, slot: j_q, release_out: pend_rel_q,
                           value_out: pend_val_q, last: 1'b0};
                more_d = 1'b1;
              end else begin
                out_valid_d = 1'b0;
                state_d     = vdht_pkg::S_FK_START;
              end
            end else if (pend_q) begin
              out_d = '{status: vdht_pkg::ST_OK, slot: j_q, release_out: pend_rel_q,
                        value_out: pend_val_q, last: 1'b1};
            end
          end
        endcase
      end

      vdht_pkg::S_EMIT: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          state_d     = more_q ? vdht_pkg::S_FK_START : vdht_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = vdht_pkg::S_IDLE;
      end
    endcase
  end

  `VDHT_ASSERT_IMP(a_probe_in_range, clk_i, rst_ni, state_q == vdht_pkg::S_PRB_CHK, (j_q < sz_q) && (n_q < sz_q), "probe index or walk count out of range")
  `VDHT_ASSERT_IMP(a_fail_no_release, clk_i, rst_ni, out_valid_o && out_data_o.status != vdht_pkg::ST_OK, out_data_o.release_out == 16'd0 && out_data_o.value_out == 32'd0, "failure result carries a release")
  `VDHT_ASSERT_NXT(a_emit_holds, clk_i, rst_ni, state_q == vdht_pkg::S_EMIT && out_stall_i, state_q == vdht_pkg::S_EMIT && out_valid_o, "result dropped while stalled")

endmodule

`default_nettype wire
